@@ rtl/pffa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pffa_pkg: shared types and constants of the paged first-fit allocator
// Request and response payloads, status codes, register indexes, ALU flags.
// ----------------------------------------------------------------------------
package pffa_pkg;

	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = 16;
	localparam int SIZE_W     = 32;
	localparam int ALIGN_W    = 5;
	localparam int PS_W       = 40;
	localparam int OFS_W      = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES      = 2'd1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_PAGE   = 2'd1,
		STAT_LIST_FULL = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic                opcode;
		logic [SIZE_W-1:0]   alloc_size;
		logic [ALIGN_W-1:0]  align_log2;
		logic [PS_W-1:0]     block_start;
		logic [PS_W-1:0]     block_end;
	} alloc_req_t;

	typedef struct packed {
		status_t             status;
		logic [PS_W-1:0]     page_start;
		logic [OFS_W-1:0]    offset_in_page;
	} alloc_rsp_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} alu_flags_t;

endpackage
`default_nettype wire

@@ rtl/pffa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pffa_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/pffa_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pffa_alu: shared add / subtract / compare unit
// One adder serves every address sum, difference and magnitude compare.
// ----------------------------------------------------------------------------
module pffa_alu import pffa_pkg::*; #(
	parameter int W = 42
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic      [W-1:0] res,
	output alu_flags_t        flags
);

	logic [W:0] sum;

	// a - b as a + ~b + 1; carry out set means a >= b
	assign sum       = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign res       = sum[W-1:0];
	assign flags.lt  = sub & ~sum[W];
	assign flags.eq  = (sum[W-1:0] == '0);

endmodule
`default_nettype wire

@@ rtl/paged_first_fit_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// paged_first_fit_allocator_top: first-fit allocator over appended pages
// Sorted free list with coalescing, per-page allocation counts.
// ----------------------------------------------------------------------------
// One request is in work at a time; a result waits in an output register while
// the next request is taken. An allocate inspects the free ranges in order and
// checks the page entries for the one that holds a fitting range; when none
// fits it appends a page and walks the free list again. A removal shifts the
// free list down one entry at a time. A free scans the page entries, walks the
// free ranges to find its neighbors, runs the merge checks and shifts entries
// on insert or removal; dropping a page sweeps the whole free list and shifts
// the page table down. All of this work is serialized on the one shared adder
// and the single read port of each table.
// Status: 0 ok, 1 no page capacity, 2 free list full, 3 block not in any page.
module paged_first_fit_allocator_top import pffa_pkg::*; #(
	parameter int MAX_PAGES       = 16,
	parameter int MAX_FREE_BLOCKS = 64,
	parameter int ADDR_BITS       = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire alloc_req_t           req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output alloc_rsp_t                rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int AW  = ADDR_BITS;
	localparam int WW  = ((AW > 33) ? AW : 33) + 2;
	localparam int FAW = $clog2(MAX_FREE_BLOCKS);
	localparam int FCW = $clog2(MAX_FREE_BLOCKS + 1);
	localparam int PAW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int CMW = (PCW > CFG_W) ? PCW : CFG_W;
	localparam int FW  = 2 * AW;
	localparam int PW  = 2 * AW + CNT_W;
	localparam logic [WW-1:0] AMASK = {{(WW-AW){1'b0}}, {AW{1'b1}}};

	typedef enum logic [45:0] {
		S_IDLE   = 46'd1 << 0,  S_DONE   = 46'd1 << 1,  S_A_SIZE = 46'd1 << 2,
		S_A_RD   = 46'd1 << 3,  S_A_PAD  = 46'd1 << 4,  S_A_PADS = 46'd1 << 5,
		S_A_NEED = 46'd1 << 6,  S_A_HAVE = 46'd1 << 7,  S_A_CMP  = 46'd1 << 8,
		S_A_PRD  = 46'd1 << 9,  S_A_PLO  = 46'd1 << 10, S_A_PHI  = 46'd1 << 11,
		S_A_NEWLO = 46'd1 << 12, S_A_OFS = 46'd1 << 13, S_N_CHK  = 46'd1 << 14,
		S_N_LAST = 46'd1 << 15, S_N_LEN  = 46'd1 << 16, S_N_ROOM = 46'd1 << 17,
		S_N_FIT  = 46'd1 << 18, S_N_END  = 46'd1 << 19, S_F_ORD  = 46'd1 << 20,
		S_F_PRD  = 46'd1 << 21, S_F_PLO  = 46'd1 << 22, S_F_PHI  = 46'd1 << 23,
		S_F_CNT  = 46'd1 << 24, S_C_RD   = 46'd1 << 25, S_C_LO   = 46'd1 << 26,
		S_C_HI   = 46'd1 << 27, S_P_RD   = 46'd1 << 28, S_P_WR   = 46'd1 << 29,
		S_B_RD   = 46'd1 << 30, S_B_CMP  = 46'd1 << 31, S_AN_CAP = 46'd1 << 32,
		S_AF_RD  = 46'd1 << 33, S_AF_CMP = 46'd1 << 34, S_MB1    = 46'd1 << 35,
		S_MB2    = 46'd1 << 36, S_MB3    = 46'd1 << 37, S_MA1    = 46'd1 << 38,
		S_MA2    = 46'd1 << 39, S_MA3    = 46'd1 << 40, S_F_UPD  = 46'd1 << 41,
		S_RM_RD  = 46'd1 << 42, S_RM_WR  = 46'd1 << 43, S_IN_RD  = 46'd1 << 44,
		S_IN_WR  = 46'd1 << 45
	} state_t;

	function automatic logic [WW-1:0] low_mask(input logic [4:0] lg);
		low_mask = ~({WW{1'b1}} << lg);
	endfunction

	function automatic alloc_rsp_t err_rsp(input status_t st);
		alloc_rsp_t r;
		r                = '0;
		r.status         = st;
		err_rsp          = r;
	endfunction

	state_t             state_q;
	logic [CFG_W-1:0]   psl_q;
	logic [CFG_W-1:0]   maxp_q;
	logic [FCW-1:0]     fcnt_q;
	logic [PCW-1:0]     pcnt_q;
	logic [FCW-1:0]     i_q, k_q, r_q, w_q, bi_q, ai_q, ins_q;
	logic [PCW-1:0]     p_q;
	logic               pass_q, exact_q, es_eq_q, bv_q, av_q, mb_q, ma_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] alg_q;
	logic [WW-1:0]      s_q, e_q, sized_q, lo_q, hi_q, t_q, need_q, have_q;
	logic [WW-1:0]      b_lo_q, b_hi_q, a_lo_q, a_hi_q;
	logic [AW-1:0]      pg_lo_q, pg_hi_q;
	logic [CNT_W-1:0]   pg_cnt_q;
	alloc_rsp_t         res_q, rsp_q;
	logic               rsp_valid_q;

	// shared unit
	logic [WW-1:0]      alu_a, alu_b, alu_res;
	logic               alu_sub;
	alu_flags_t         alu_f;

	// tables
	logic               free_we, page_we;
	logic [FAW-1:0]     free_waddr, free_raddr;
	logic [PAW-1:0]     page_waddr, page_raddr;
	logic [FW-1:0]      free_wdata, free_rdata;
	logic [PW-1:0]      page_wdata, page_rdata;

	logic [WW-1:0]      fr_lo, fr_hi, pr_lo, pr_hi, amask, pmask;
	logic [FCW-1:0]     kp1, km1;
	logic [PCW-1:0]     pp1, pm1;
	logic [CNT_W-1:0]   cnt_inc;
	logic               page_full, list_full, upd_err;

	assign fr_lo   = WW'(free_rdata[FW-1:AW]);
	assign fr_hi   = WW'(free_rdata[AW-1:0]);
	assign pr_lo   = WW'(page_rdata[PW-1:AW+CNT_W]);
	assign pr_hi   = WW'(page_rdata[AW+CNT_W-1:CNT_W]);
	assign amask   = low_mask(alg_q);
	assign pmask   = low_mask(psl_q);
	assign kp1     = k_q + FCW'(1);
	assign km1     = k_q - FCW'(1);
	assign pp1     = p_q + PCW'(1);
	assign pm1     = pcnt_q - PCW'(1);
	assign cnt_inc = (pg_cnt_q == CNT_MAX) ? pg_cnt_q : pg_cnt_q + CNT_W'(1);
	assign page_full = (pcnt_q >= PCW'(MAX_PAGES)) || (CMW'(pcnt_q) >= CMW'(maxp_q));
	assign list_full = (fcnt_q >= FCW'(MAX_FREE_BLOCKS));
	assign upd_err   = !mb_q && !ma_q && !es_eq_q && list_full;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	pffa_alu #(.W(WW)) u_alu (
		.a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .flags(alu_f)
	);

	pffa_ram #(.WIDTH(FW), .DEPTH(MAX_FREE_BLOCKS), .ADDR_W(FAW)) u_free_ram (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.raddr(free_raddr), .rdata(free_rdata)
	);

	pffa_ram #(.WIDTH(PW), .DEPTH(MAX_PAGES), .ADDR_W(PAW)) u_page_ram (
		.clk(clk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
		.raddr(page_raddr), .rdata(page_rdata)
	);

	// select operands of the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_A_SIZE:  begin alu_a = WW'(size_q); alu_b = amask; alu_sub = 1'b0; end
			S_A_PAD:   begin alu_a = fr_lo; alu_b = amask; alu_sub = 1'b0; end
			S_A_PADS:  begin alu_a = t_q; alu_b = lo_q; end
			S_A_NEED:  begin alu_a = sized_q; alu_b = t_q; alu_sub = 1'b0; end
			S_A_HAVE:  begin alu_a = hi_q; alu_b = lo_q; end
			S_A_CMP:   begin alu_a = have_q; alu_b = need_q; end
			S_A_PLO:   begin alu_a = lo_q; alu_b = pr_lo; end
			S_A_PHI:   begin alu_a = lo_q; alu_b = WW'(pg_hi_q); end
			S_A_NEWLO: begin alu_a = lo_q; alu_b = need_q; alu_sub = 1'b0; end
			S_A_OFS:   begin alu_a = lo_q; alu_b = WW'(pg_lo_q); end
			S_N_LEN:   begin
				alu_a   = (sized_q == '0) ? WW'(1) : sized_q;
				alu_b   = pmask;
				alu_sub = 1'b0;
			end
			S_N_ROOM:  begin alu_a = AMASK; alu_b = lo_q; end
			S_N_FIT:   begin alu_a = have_q; alu_b = need_q; end
			S_N_END:   begin alu_a = lo_q; alu_b = need_q; alu_sub = 1'b0; end
			S_F_ORD:   begin alu_a = e_q; alu_b = s_q; end
			S_F_PLO:   begin alu_a = s_q; alu_b = pr_lo; end
			S_F_PHI:   begin alu_a = WW'(pg_hi_q); alu_b = e_q; end
			S_C_LO:    begin alu_a = fr_lo; alu_b = WW'(pg_lo_q); end
			S_C_HI:    begin alu_a = WW'(pg_hi_q); alu_b = hi_q; end
			S_B_CMP:   begin alu_a = s_q; alu_b = fr_hi; end
			S_AF_CMP:  begin alu_a = fr_lo; alu_b = e_q; end
			S_MB1:     begin alu_a = b_lo_q; alu_b = WW'(pg_lo_q); end
			S_MB2:     begin alu_a = WW'(pg_hi_q); alu_b = b_hi_q; end
			S_MB3:     begin alu_a = b_hi_q; alu_b = s_q; end
			S_MA1:     begin alu_a = a_lo_q; alu_b = WW'(pg_lo_q); end
			S_MA2:     begin alu_a = WW'(pg_hi_q); alu_b = a_hi_q; end
			S_MA3:     begin alu_a = a_lo_q; alu_b = e_q; end
			default:   begin alu_a = '0; alu_b = '0; end
		endcase
	end

	// drive table read addresses and writes
	always_comb begin
		free_raddr = i_q[FAW-1:0];
		page_raddr = p_q[PAW-1:0];
		free_we    = 1'b0;
		free_waddr = i_q[FAW-1:0];
		free_wdata = '0;
		page_we    = 1'b0;
		page_waddr = p_q[PAW-1:0];
		page_wdata = '0;
		unique case (state_q)
			S_B_RD:   free_raddr = km1[FAW-1:0];
			S_B_CMP:  free_raddr = k_q[FAW-1:0];
			S_C_RD:   free_raddr = r_q[FAW-1:0];
			S_RM_RD:  free_raddr = kp1[FAW-1:0];
			S_IN_RD:  begin
				free_raddr = km1[FAW-1:0];
				if (k_q == ins_q) begin
					free_we    = 1'b1;
					free_waddr = ins_q[FAW-1:0];
					free_wdata = {s_q[AW-1:0], e_q[AW-1:0]};
				end
			end
			S_IN_WR:  begin
				free_we    = 1'b1;
				free_waddr = k_q[FAW-1:0];
				free_wdata = free_rdata;
			end
			S_RM_WR:  begin
				free_we    = 1'b1;
				free_waddr = k_q[FAW-1:0];
				free_wdata = free_rdata;
			end
			S_N_CHK:  page_raddr = pm1[PAW-1:0];
			S_P_RD:   page_raddr = pp1[PAW-1:0];
			S_P_WR:   begin
				page_we    = 1'b1;
				page_wdata = page_rdata;
			end
			S_A_NEWLO: begin
				free_we    = !exact_q;
				free_wdata = {alu_res[AW-1:0], hi_q[AW-1:0]};
				page_we    = 1'b1;
				page_wdata = {pg_lo_q, pg_hi_q, cnt_inc};
			end
			S_N_END:  begin
				page_we    = 1'b1;
				page_waddr = pcnt_q[PAW-1:0];
				page_wdata = {lo_q[AW-1:0], alu_res[AW-1:0], {CNT_W{1'b0}}};
				free_we    = 1'b1;
				free_waddr = fcnt_q[FAW-1:0];
				free_wdata = {lo_q[AW-1:0], alu_res[AW-1:0]};
			end
			S_C_LO:   begin
				free_we    = alu_f.lt;
				free_waddr = w_q[FAW-1:0];
				free_wdata = free_rdata;
			end
			S_C_HI:   begin
				free_we    = alu_f.lt;
				free_waddr = w_q[FAW-1:0];
				free_wdata = {lo_q[AW-1:0], hi_q[AW-1:0]};
			end
			S_F_UPD:  begin
				page_we    = !upd_err;
				page_wdata = {pg_lo_q, pg_hi_q, pg_cnt_q - CNT_W'(1)};
				if (!upd_err && mb_q) begin
					free_we    = 1'b1;
					free_waddr = bi_q[FAW-1:0];
					free_wdata = {b_lo_q[AW-1:0], (ma_q ? a_hi_q[AW-1:0] : e_q[AW-1:0])};
				end else if (!upd_err && ma_q) begin
					free_we    = 1'b1;
					free_waddr = ai_q[FAW-1:0];
					free_wdata = {s_q[AW-1:0], a_hi_q[AW-1:0]};
				end
			end
			default:  begin
				free_we = 1'b0;
				page_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			psl_q       <= CFG_W'(16);
			maxp_q      <= CFG_W'(16);
			fcnt_q      <= '0;
			pcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			res_q       <= '0;
			i_q <= '0; k_q <= '0; r_q <= '0; w_q <= '0;
			bi_q <= '0; ai_q <= '0; ins_q <= '0; p_q <= '0;
			pass_q <= 1'b0; exact_q <= 1'b0; es_eq_q <= 1'b0;
			bv_q <= 1'b0; av_q <= 1'b0; mb_q <= 1'b0; ma_q <= 1'b0;
			size_q <= '0; alg_q <= '0;
			s_q <= '0; e_q <= '0; sized_q <= '0; lo_q <= '0; hi_q <= '0;
			t_q <= '0; need_q <= '0; have_q <= '0;
			b_lo_q <= '0; b_hi_q <= '0; a_lo_q <= '0; a_hi_q <= '0;
			pg_lo_q <= '0; pg_hi_q <= '0; pg_cnt_q <= '0;
		end else begin
			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PAGE_SIZE_LOG2: psl_q  <= cfg_data;
					CFG_MAX_PAGES:      maxp_q <= cfg_data;
					default:            ;
				endcase
			end

			// load a finished response, or drop one once taken
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						size_q  <= req.alloc_size;
						alg_q   <= req.align_log2;
						s_q     <= WW'(req.block_start) & AMASK;
						e_q     <= WW'(req.block_end) & AMASK;
						state_q <= (req.opcode == OP_FREE) ? S_F_ORD : S_A_SIZE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end

				// allocate: round size, then walk the free list
				S_A_SIZE: begin
					sized_q <= alu_res & ~amask;
					pass_q  <= 1'b0;
					i_q     <= '0;
					state_q <= S_A_RD;
				end
				S_A_RD: begin
					if (i_q == fcnt_q) begin
						if (pass_q) begin
							res_q   <= err_rsp(STAT_NO_PAGE);
							state_q <= S_DONE;
						end else begin
							state_q <= S_N_CHK;
						end
					end else begin
						state_q <= S_A_PAD;
					end
				end
				S_A_PAD: begin
					lo_q    <= fr_lo;
					hi_q    <= fr_hi;
					t_q     <= alu_res & ~amask;
					state_q <= S_A_PADS;
				end
				S_A_PADS: begin t_q <= alu_res; state_q <= S_A_NEED; end
				S_A_NEED: begin need_q <= alu_res; state_q <= S_A_HAVE; end
				S_A_HAVE: begin have_q <= alu_res; state_q <= S_A_CMP; end
				S_A_CMP: begin
					if (alu_f.lt) begin
						i_q     <= i_q + FCW'(1);
						state_q <= S_A_RD;
					end else begin
						exact_q <= alu_f.eq;
						p_q     <= '0;
						state_q <= S_A_PRD;
					end
				end
				S_A_PRD: begin
					if (p_q == pcnt_q) begin
						i_q     <= i_q + FCW'(1);
						state_q <= S_A_RD;
					end else begin
						state_q <= S_A_PLO;
					end
				end
				S_A_PLO: begin
					pg_lo_q  <= pr_lo[AW-1:0];
					pg_hi_q  <= pr_hi[AW-1:0];
					pg_cnt_q <= page_rdata[CNT_W-1:0];
					if (alu_f.lt) begin
						p_q     <= p_q + PCW'(1);
						state_q <= S_A_PRD;
					end else begin
						state_q <= S_A_PHI;
					end
				end
				S_A_PHI: begin
					if (alu_f.lt) begin
						state_q <= S_A_NEWLO;
					end else begin
						p_q     <= p_q + PCW'(1);
						state_q <= S_A_PRD;
					end
				end
				S_A_NEWLO: state_q <= S_A_OFS;
				S_A_OFS: begin
					res_q.status         <= STAT_OK;
					res_q.page_start     <= PS_W'(pg_lo_q);
					res_q.offset_in_page <= alu_res[OFS_W-1:0];
					k_q                  <= i_q;
					state_q              <= exact_q ? S_RM_RD : S_DONE;
				end

				// append a page and retry
				S_N_CHK: begin
					if (page_full) begin
						res_q   <= err_rsp(STAT_NO_PAGE);
						state_q <= S_DONE;
					end else if (list_full) begin
						res_q   <= err_rsp(STAT_LIST_FULL);
						state_q <= S_DONE;
					end else if (pcnt_q == '0) begin
						lo_q    <= '0;
						state_q <= S_N_LEN;
					end else begin
						state_q <= S_N_LAST;
					end
				end
				S_N_LAST: begin lo_q <= pr_hi; state_q <= S_N_LEN; end
				S_N_LEN:  begin need_q <= alu_res & ~pmask; state_q <= S_N_ROOM; end
				S_N_ROOM: begin have_q <= alu_res; state_q <= S_N_FIT; end
				S_N_FIT: begin
					if (alu_f.lt) begin
						res_q   <= err_rsp(STAT_NO_PAGE);
						state_q <= S_DONE;
					end else begin
						state_q <= S_N_END;
					end
				end
				S_N_END: begin
					pcnt_q  <= pcnt_q + PCW'(1);
					fcnt_q  <= fcnt_q + FCW'(1);
					pass_q  <= 1'b1;
					i_q     <= '0;
					state_q <= S_A_RD;
				end

				// free: locate the page
				S_F_ORD: begin
					es_eq_q <= alu_f.eq;
					p_q     <= '0;
					if (alu_f.lt) begin
						res_q   <= err_rsp(STAT_NOT_FOUND);
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_PRD;
					end
				end
				S_F_PRD: begin
					if (p_q == pcnt_q) begin
						res_q   <= err_rsp(STAT_NOT_FOUND);
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_PLO;
					end
				end
				S_F_PLO: begin
					pg_lo_q  <= pr_lo[AW-1:0];
					pg_hi_q  <= pr_hi[AW-1:0];
					pg_cnt_q <= page_rdata[CNT_W-1:0];
					if (alu_f.lt) begin
						p_q     <= p_q + PCW'(1);
						state_q <= S_F_PRD;
					end else begin
						state_q <= S_F_PHI;
					end
				end
				S_F_PHI: begin
					if (alu_f.lt) begin
						p_q     <= p_q + PCW'(1);
						state_q <= S_F_PRD;
					end else begin
						state_q <= S_F_CNT;
					end
				end
				S_F_CNT: begin
					r_q <= '0;
					w_q <= '0;
					k_q <= fcnt_q;
					if (pg_cnt_q == '0) begin
						res_q   <= err_rsp(STAT_NOT_FOUND);
						state_q <= S_DONE;
					end else if (pg_cnt_q == CNT_W'(1)) begin
						state_q <= S_C_RD;
					end else begin
						state_q <= S_B_RD;
					end
				end

				// last allocation gone: squeeze the page's ranges out of the list
				S_C_RD: begin
					if (r_q == fcnt_q) begin
						fcnt_q  <= w_q;
						state_q <= S_P_RD;
					end else begin
						state_q <= S_C_LO;
					end
				end
				S_C_LO: begin
					lo_q <= fr_lo;
					hi_q <= fr_hi;
					if (alu_f.lt) begin
						w_q     <= w_q + FCW'(1);
						r_q     <= r_q + FCW'(1);
						state_q <= S_C_RD;
					end else begin
						state_q <= S_C_HI;
					end
				end
				S_C_HI: begin
					if (alu_f.lt) begin
						w_q <= w_q + FCW'(1);
					end
					r_q     <= r_q + FCW'(1);
					state_q <= S_C_RD;
				end
				S_P_RD: begin
					if (pp1 == pcnt_q) begin
						pcnt_q  <= pm1;
						res_q   <= err_rsp(STAT_OK);
						state_q <= S_DONE;
					end else begin
						state_q <= S_P_WR;
					end
				end
				S_P_WR: begin p_q <= pp1; state_q <= S_P_RD; end

				// neighbor search
				S_B_RD: begin
					if (k_q == '0) begin
						bv_q    <= 1'b0;
						i_q     <= '0;
						state_q <= S_AF_RD;
					end else begin
						state_q <= S_B_CMP;
					end
				end
				S_B_CMP: begin
					b_lo_q <= fr_lo;
					b_hi_q <= fr_hi;
					if (alu_f.lt) begin
						k_q     <= km1;
						state_q <= S_B_RD;
					end else begin
						bv_q <= 1'b1;
						bi_q <= km1;
						ai_q <= k_q;
						if (k_q < fcnt_q) begin
							state_q <= S_AN_CAP;
						end else begin
							av_q    <= 1'b0;
							state_q <= S_MB1;
						end
					end
				end
				S_AN_CAP: begin
					a_lo_q  <= fr_lo;
					a_hi_q  <= fr_hi;
					av_q    <= 1'b1;
					state_q <= S_MB1;
				end
				S_AF_RD: begin
					if (i_q == fcnt_q) begin
						av_q    <= 1'b0;
						state_q <= S_MB1;
					end else begin
						state_q <= S_AF_CMP;
					end
				end
				S_AF_CMP: begin
					a_lo_q <= fr_lo;
					a_hi_q <= fr_hi;
					if (alu_f.lt) begin
						i_q     <= i_q + FCW'(1);
						state_q <= S_AF_RD;
					end else begin
						av_q    <= 1'b1;
						ai_q    <= i_q;
						state_q <= S_MB1;
					end
				end

				// merge checks against the page bounds and the freed range
				S_MB1: begin mb_q <= bv_q & ~alu_f.lt; state_q <= S_MB2; end
				S_MB2: begin mb_q <= mb_q & ~alu_f.lt; state_q <= S_MB3; end
				S_MB3: begin mb_q <= mb_q & alu_f.eq; state_q <= S_MA1; end
				S_MA1: begin ma_q <= av_q & ~alu_f.lt; state_q <= S_MA2; end
				S_MA2: begin ma_q <= ma_q & ~alu_f.lt; state_q <= S_MA3; end
				S_MA3: begin ma_q <= ma_q & alu_f.eq; state_q <= S_F_UPD; end
				S_F_UPD: begin
					k_q   <= mb_q ? ai_q : fcnt_q;
					ins_q <= bv_q ? (bi_q + FCW'(1)) : '0;
					if (upd_err) begin
						res_q   <= err_rsp(STAT_LIST_FULL);
						state_q <= S_DONE;
					end else begin
						res_q <= err_rsp(STAT_OK);
						if (mb_q && ma_q) begin
							state_q <= S_RM_RD;
						end else if (mb_q || ma_q || es_eq_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_IN_RD;
						end
					end
				end

				// shift down over a removed range
				S_RM_RD: begin
					if (kp1 == fcnt_q) begin
						fcnt_q  <= fcnt_q - FCW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin k_q <= kp1; state_q <= S_RM_RD; end

				// shift up to open a slot, then place the range
				S_IN_RD: begin
					if (k_q == ins_q) begin
						fcnt_q  <= fcnt_q + FCW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_IN_WR;
					end
				end
				S_IN_WR: begin k_q <= km1; state_q <= S_IN_RD; end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// counts stay within the table depths
	a_fcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCW'(MAX_FREE_BLOCKS))
		else $error("free count beyond list depth");

	a_pcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCW'(MAX_PAGES))
		else $error("page count beyond table depth");

	// an accepted request always starts work
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q != S_IDLE)
		else $error("accepted request did not start");

	// pages are added or dropped one at a time
	a_pcnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (pcnt_q == $past(pcnt_q) || pcnt_q == $past(pcnt_q) + PCW'(1)
			|| pcnt_q == $past(pcnt_q) - PCW'(1)))
		else $error("page count jumped");

endmodule
`default_nettype wire

@@ tb/sv/paged_first_fit_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_first_fit_allocator_top_tb: self-checking bench of the page allocator
// Drives allocate and free requests through the valid/stall channel and keeps
// a software copy of the page table and free list. The copy predicts every
// response, and the checker compares them in order. The bench covers directed
// corners, page limits, a full free list, back-pressure and random traffic.
// ----------------------------------------------------------------------------
module paged_first_fit_allocator_top_tb;
	import pffa_pkg::*;

	typedef logic [63:0] u64;
	typedef struct {
		u64 lo;
		u64 hi;
	} span_t;

	localparam int N_PAGES  = 16;
	localparam int N_FREE   = 64;
	localparam u64 ADDR_MSK = (64'd1 << 40) - 64'd1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	alloc_req_t           req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	alloc_rsp_t           rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Shadow allocator state
	u64 pg_lo [N_PAGES];
	u64 pg_hi [N_PAGES];
	int pg_allocs [N_PAGES];
	int n_pages;
	u64 fr_lo [N_FREE];
	u64 fr_hi [N_FREE];
	int n_free;
	int page_lg;
	int page_limit;

	alloc_rsp_t rsp_expected_q[$];
	span_t      live_q[$];
	int         errors;
	int         n_status[4];
	int         n_sent;
	int         gap_pct;
	int         stall_pct;
	int         hold_left = 0;
	event       hold_go;

	paged_first_fit_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#400ms;
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Allocation predictor
	// ------------------------------------------------------------------------
	function automatic u64 align_up(u64 v, int lg);
		u64 a;
		a = 64'd1 << (lg & 31);
		return (v + a - 64'd1) & ~(a - 64'd1);
	endfunction

	function automatic void span_remove(int i);
		for (int k = i; k + 1 < n_free; k++) begin
			fr_lo[k] = fr_lo[k+1];
			fr_hi[k] = fr_hi[k+1];
		end
		n_free--;
	endfunction

	function automatic void span_insert(int i, u64 lo, u64 hi);
		for (int k = n_free; k > i; k--) begin
			fr_lo[k] = fr_lo[k-1];
			fr_hi[k] = fr_hi[k-1];
		end
		fr_lo[i] = lo;
		fr_hi[i] = hi;
		n_free++;
	endfunction

	function automatic bit span_in_page(u64 lo, u64 hi, int p);
		return lo >= pg_lo[p] && hi <= pg_hi[p];
	endfunction

	// Take the first free span that holds the padded size.
	function automatic bit first_fit(u64 sized, int alg, inout alloc_rsp_t o,
			output u64 got_lo, output u64 got_hi);
		u64 lo, need, have, ofs;
		int p;
		got_lo = 0;
		got_hi = 0;
		for (int i = 0; i < n_free; i++) begin
			lo = fr_lo[i];
			need = sized + (align_up(lo, alg) - lo);
			have = fr_hi[i] - lo;
			if (have < need)
				continue;
			p = 0;
			while (p < n_pages && !(pg_lo[p] <= lo && pg_hi[p] > lo))
				p++;
			if (p == n_pages)
				continue;
			fr_lo[i] = lo + need;
			if (have == need)
				span_remove(i);
			if (pg_allocs[p] < 65535)
				pg_allocs[p]++;
			ofs = lo - pg_lo[p];
			o.page_start = pg_lo[p][39:0];
			o.offset_in_page = ofs[31:0];
			got_lo = lo;
			got_hi = lo + need;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic status_t predict_alloc(u64 size, int alg, inout alloc_rsp_t o,
			output u64 got_lo, output u64 got_hi);
		int lim;
		u64 sized, base, len;
		lim = page_limit < N_PAGES ? page_limit : N_PAGES;
		sized = align_up(size, alg);
		if (first_fit(sized, alg, o, got_lo, got_hi))
			return STAT_OK;
		if (n_pages >= lim)
			return STAT_NO_PAGE;
		if (n_free >= N_FREE)
			return STAT_LIST_FULL;
		base = n_pages != 0 ? pg_hi[n_pages-1] : 64'd0;
		len = align_up(sized != 0 ? sized : 64'd1, page_lg);
		if (len > ADDR_MSK - base)
			return STAT_NO_PAGE;
		pg_lo[n_pages] = base;
		pg_hi[n_pages] = base + len;
		pg_allocs[n_pages] = 0;
		n_pages++;
		span_insert(n_free, base, base + len);
		if (first_fit(sized, alg, o, got_lo, got_hi))
			return STAT_OK;
		return STAT_NO_PAGE;
	endfunction

	function automatic status_t predict_free(u64 s, u64 e);
		int p, prv, nxt;
		bit join_prv, join_nxt;
		prv = -1;
		nxt = -1;
		if (e < s)
			return STAT_NOT_FOUND;
		p = 0;
		while (p < n_pages && !span_in_page(s, e, p))
			p++;
		if (p == n_pages || pg_allocs[p] == 0)
			return STAT_NOT_FOUND;
		// last allocation of the page: drop the page and its free spans
		if (pg_allocs[p] == 1) begin
			for (int k = n_free; k > 0; k--)
				if (span_in_page(fr_lo[k-1], fr_hi[k-1], p))
					span_remove(k - 1);
			for (int k = p; k + 1 < n_pages; k++) begin
				pg_lo[k] = pg_lo[k+1];
				pg_hi[k] = pg_hi[k+1];
				pg_allocs[k] = pg_allocs[k+1];
			end
			n_pages--;
			return STAT_OK;
		end
		for (int k = n_free; k > 0; k--)
			if (fr_hi[k-1] <= s) begin
				prv = k - 1;
				break;
			end
		if (prv >= 0) begin
			if (prv + 1 < n_free)
				nxt = prv + 1;
		end else begin
			for (int k = 0; k < n_free; k++)
				if (fr_lo[k] >= e) begin
					nxt = k;
					break;
				end
		end
		join_prv = prv >= 0 && span_in_page(fr_lo[prv], fr_hi[prv], p) && fr_hi[prv] == s;
		join_nxt = nxt >= 0 && span_in_page(fr_lo[nxt], fr_hi[nxt], p) && fr_lo[nxt] == e;
		if (!join_prv && !join_nxt && e != s && n_free >= N_FREE)
			return STAT_LIST_FULL;
		pg_allocs[p]--;
		if (join_prv && join_nxt) begin
			fr_hi[prv] = fr_hi[nxt];
			span_remove(nxt);
		end else if (join_prv) begin
			fr_hi[prv] = e;
		end else if (join_nxt) begin
			fr_lo[nxt] = s;
		end else if (e != s) begin
			span_insert(prv >= 0 ? prv + 1 : 0, s, e);
		end
		return STAT_OK;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	task automatic send_request(input alloc_req_t r, output bit ok,
			output u64 got_lo, output u64 got_hi);
		alloc_rsp_t o;
		int gap;
		o = '0;
		got_lo = 0;
		got_hi = 0;
		if (r.opcode == OP_ALLOC)
			o.status = predict_alloc({32'd0, r.alloc_size}, int'(r.align_log2), o,
				got_lo, got_hi);
		else
			o.status = predict_free({24'd0, r.block_start}, {24'd0, r.block_end});
		if (o.status != STAT_OK) begin
			o.page_start = '0;
			o.offset_in_page = '0;
		end
		ok = o.status == STAT_OK;
		rsp_expected_q.insert(rsp_expected_q.size(), o);
		n_sent++;
		// idle the sender for a random stretch
		gap = 0;
		while (gap < 20 && $urandom_range(99) < gap_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	function automatic alloc_req_t junk_request();
		alloc_req_t r;
		r.opcode = OP_ALLOC;
		r.alloc_size = $urandom;
		r.align_log2 = 5'($urandom_range(0, 31));
		r.block_start = 40'({$urandom, $urandom});
		r.block_end = 40'({$urandom, $urandom});
		return r;
	endfunction

	task automatic alloc_block(input logic [31:0] size, input int alg,
			output bit ok, output span_t sp);
		alloc_req_t r;
		r = junk_request();
		r.opcode = OP_ALLOC;
		r.alloc_size = size;
		r.align_log2 = 5'(alg);
		send_request(r, ok, sp.lo, sp.hi);
		if (ok)
			live_q.insert(live_q.size(), sp);
	endtask

	task automatic free_range(input u64 s, input u64 e, output bit ok);
		alloc_req_t r;
		u64 d0, d1;
		r = junk_request();
		r.opcode = OP_FREE;
		r.block_start = s[39:0];
		r.block_end = e[39:0];
		send_request(r, ok, d0, d1);
	endtask

	task automatic free_live(input int idx);
		bit ok;
		span_t sp;
		sp = live_q[idx];
		live_q.delete(idx);
		free_range(sp.lo, sp.hi, ok);
	endtask

	// Lower valid and drain every outstanding response.
	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_expected_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic release_all();
		while (live_q.size() != 0)
			free_live(0);
		drain();
	endtask

	task automatic write_regs(input int lg, input int lim);
		cfg_index <= CFG_PAGE_SIZE_LOG2;
		cfg_data <= lg[CFG_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MAX_PAGES;
		cfg_data <= lim[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		page_lg = lg & 31;
		page_limit = lim & 31;
	endtask

	// ------------------------------------------------------------------------
	// Response checker and receiver stall
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		alloc_rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected_q.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp);
				errors++;
			end else begin
				exp_rsp = rsp_expected_q.pop_front();
				n_status[exp_rsp.status]++;
				if (rsp.status !== exp_rsp.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_rsp.status, rsp.status);
					errors++;
				end
				if (rsp.page_start !== exp_rsp.page_start) begin
					$display("%0t: page_start expected %h actual %h", $time,
						exp_rsp.page_start, rsp.page_start);
					errors++;
				end
				if (rsp.offset_in_page !== exp_rsp.offset_in_page) begin
					$display("%0t: offset_in_page expected %h actual %h", $time,
						exp_rsp.offset_in_page, rsp.offset_in_page);
					errors++;
				end
			end
		end
		rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// Count down a long receiver hold-off.
	always begin
		@(hold_go);
		hold_left <= 400;
		@(posedge clk);
		while (hold_left > 0) begin
			hold_left <= hold_left - 1;
			@(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		bit ok;
		span_t sp, big;
		gap_pct = 0;
		stall_pct = 0;
		alloc_block(32'd0, 0, ok, sp);
		alloc_block(32'd100, 3, ok, sp);
		alloc_block(32'hFFFF_FFFF, 16, ok, big);
		alloc_block(32'd1, 31, ok, sp);
		free_range(64'd200, 64'd100, ok);
		free_range(ADDR_MSK - 64'd10, ADDR_MSK, ok);
		free_range(64'd0, ADDR_MSK, ok);
		// empty free still ends an allocation
		free_range(live_q[0].lo, live_q[0].lo, ok);
		live_q.delete(0);
		alloc_block(32'd7, 0, ok, sp);
		alloc_block(32'd9, 2, ok, sp);
		while (live_q.size() != 0)
			free_live(live_q.size() - 1);
		free_range(big.lo, big.hi, ok);
		drain();
	endtask

	task automatic test_page_limits();
		bit ok;
		span_t sp;
		write_regs(8, 0);
		alloc_block(32'd10, 0, ok, sp);
		drain();
		write_regs(8, 1);
		alloc_block(32'd200, 2, ok, sp);
		alloc_block(32'd100, 0, ok, sp);
		alloc_block(32'd500, 0, ok, sp);
		drain();
		write_regs(30, 31);
		for (int i = 0; i < 18; i++)
			alloc_block(32'hFFFF_FFFF, i % 5, ok, sp);
		release_all();
	endtask

	// Fragment one page until the free list overflows.
	task automatic test_list_full();
		bit ok;
		span_t blk[140];
		write_regs(16, 16);
		for (int i = 0; i < 140; i++)
			alloc_block(32'd16, 4, ok, blk[i]);
		live_q.delete();
		for (int i = 0; i < 140; i += 2)
			free_range(blk[i].lo, blk[i].hi, ok);
		// a new page needs a list entry too
		alloc_block(32'd70000, 0, ok, blk[0]);
		for (int i = 1; i < 140; i += 2)
			free_range(blk[i].lo, blk[i].hi, ok);
		for (int i = 126; i < 140; i += 2)
			free_range(blk[i].lo, blk[i].hi, ok);
		release_all();
	endtask

	task automatic test_backpressure();
		bit ok;
		span_t sp;
		write_regs(12, 16);
		gap_pct = 0;
		stall_pct = 0;
		-> hold_go;
		for (int i = 0; i < 30; i++)
			alloc_block($urandom_range(0, 3000), $urandom_range(0, 5), ok, sp);
		release_all();
	endtask

	task automatic test_random(input int lg, input int lim, input int gp, input int sp_pct,
			input int count);
		bit ok;
		span_t sp;
		alloc_req_t r;
		u64 d0, d1;
		int pick;
		write_regs(lg, lim);
		gap_pct = gp;
		stall_pct = sp_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// noise: raw request with random fields
				r = junk_request();
				r.opcode = 1'($urandom_range(1));
				send_request(r, ok, d0, d1);
			end else if (pick < 50 && live_q.size() < 40) begin
				if ($urandom_range(19) == 0)
					alloc_block($urandom, $urandom_range(0, 31), ok, sp);
				else if ($urandom_range(9) == 0)
					alloc_block($urandom_range(0, 70000), $urandom_range(0, 12), ok, sp);
				else
					alloc_block($urandom_range(0, 300), $urandom_range(0, 6), ok, sp);
			end else if (live_q.size() != 0) begin
				free_live($urandom_range(live_q.size() - 1));
			end else begin
				alloc_block($urandom_range(0, 300), $urandom_range(0, 6), ok, sp);
			end
		end
		release_all();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PAGE_SIZE_LOG2;
		cfg_data = '0;
		errors = 0;
		n_sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		n_status = '{default: 0};
		page_lg = 16;
		page_limit = 16;
		n_pages = 0;
		n_free = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_page_limits();
		test_list_full();
		test_backpressure();
		test_random(8, 16, 0, 0, 380);
		test_random(12, 4, 46, 0, 380);
		test_random(30, 31, 0, 46, 380);
		test_random(16, 1, 15, 15, 200);
		test_random(10, 16, 15, 15, 160);

		$display("Sent %0d requests over page sizes 2^8..2^30 and page limits 0..31.",
			n_sent);
		$display("Status counts: ok %0d, no page %0d, list full %0d, not found %0d.",
			n_status[0], n_status[1], n_status[2], n_status[3]);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/pffa_pkg.sv
rtl/pffa_ram.sv
rtl/pffa_alu.sv
rtl/paged_first_fit_allocator_top.sv
tb/sv/paged_first_fit_allocator_top_tb.sv
